// File: hw/rtl/kmr_pkg.sv
// ----------------------------------------------------------------------------
// kmr_pkg
// Shared types, field widths, codes and saturation helper for the Kron
// matrix reduction core.
// ----------------------------------------------------------------------------
package kmr_pkg;

	localparam int IDX_W   = 3;
	localparam int DATA_W  = 32;
	localparam int CNT_W   = 3;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_SINGULAR = 2'd1,
		STATUS_BAD_SIZE = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_PHASES   = 1'b0,
		CFG_NUM_NEUTRALS = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_COMPUTE = 1'b1
	} op_t;

	function automatic logic signed [DATA_W-1:0] sat_mag(logic [64:0] mag, logic neg);
		logic signed [DATA_W-1:0] res;
		if (neg) begin
			if (mag >= 65'h0_8000_0000)
				res = 32'sh8000_0000;
			else
				res = -$signed(mag[DATA_W-1:0]);
		end else begin
			if (mag > 65'h0_7FFF_FFFF)
				res = 32'sh7FFF_FFFF;
			else
				res = $signed(mag[DATA_W-1:0]);
		end
		return res;
	endfunction

endpackage

// File: hw/rtl/kmr_if.sv
// ----------------------------------------------------------------------------
// kmr channel interfaces
// Command channel (loads and compute requests) and result channel.
// ----------------------------------------------------------------------------
interface kmr_cmd_if;
	logic                              valid;
	logic                              ready;
	logic                              operation;
	logic [kmr_pkg::IDX_W-1:0]         entry_row;
	logic [kmr_pkg::IDX_W-1:0]         entry_col;
	logic signed [kmr_pkg::DATA_W-1:0] entry_re;
	logic signed [kmr_pkg::DATA_W-1:0] entry_im;

	modport source(output valid, operation, entry_row, entry_col, entry_re, entry_im,
		input ready);
	modport sink(input valid, operation, entry_row, entry_col, entry_re, entry_im,
		output ready);
endinterface

interface kmr_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [kmr_pkg::IDX_W-1:0]         result_row;
	logic [kmr_pkg::IDX_W-1:0]         result_col;
	logic signed [kmr_pkg::DATA_W-1:0] result_re;
	logic signed [kmr_pkg::DATA_W-1:0] result_im;
	logic                              last_of_run;
	logic [kmr_pkg::STAT_W-1:0]        status;

	modport source(output valid, result_row, result_col, result_re, result_im,
		last_of_run, status, input ready);
	modport sink(input valid, result_row, result_col, result_re, result_im,
		last_of_run, status, output ready);
endinterface

// File: hw/rtl/kmr_ram.sv
// ----------------------------------------------------------------------------
// kmr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kmr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/kmr_div.sv
// ----------------------------------------------------------------------------
// kmr_div
// Restoring divider, one quotient bit per cycle: round(num * 2^F / den)
// with ties away from zero, result saturated to 32 bits.
// ----------------------------------------------------------------------------
module kmr_div #(
	parameter int FRAC_BITS = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              neg,
	input  logic [63:0]                       num,
	input  logic [63:0]                       den,
	output logic                              busy,
	output logic signed [kmr_pkg::DATA_W-1:0] quo
);
	localparam int STEPS = 64 + FRAC_BITS;
	localparam int CW = $clog2(STEPS + 1);
	localparam logic [34:0] CAP = 35'h2_0000_0000;

	logic        busy_q;
	logic [CW-1:0] cnt_q;
	logic [63:0] num_q, den_q;
	logic [64:0] r_q;
	logic [34:0] q_q;
	logic        neg_q;
	logic signed [kmr_pkg::DATA_W-1:0] quo_q;

	logic [64:0] rs, rn;
	logic [34:0] qs, qn, qr;
	logic        qbit;

	always_comb begin
		rs = {r_q[63:0], num_q[63]};
		qbit = (rs >= {1'b0, den_q});
		rn = qbit ? rs - {1'b0, den_q} : rs;
		qs = {q_q[33:0], qbit};
		qn = (qs > CAP) ? CAP : qs;
		qr = ({rn[63:0], 1'b0} >= {1'b0, den_q}) ? qn + 35'd1 : qn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			neg_q <= neg;
			r_q   <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			r_q   <= rn;
			q_q   <= qn;
			if (cnt_q == CW'(STEPS - 1))
				quo_q <= kmr_pkg::sat_mag(65'(qr), neg_q);
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule

// File: hw/rtl/kron_matrix_reduction_core.sv
// ----------------------------------------------------------------------------
// kron_matrix_reduction_core
// Kron reduction (Schur complement) of a complex conductor impedance matrix.
//
// cfg_we/cfg_idx/cfg_data write num_phases (index 0) and num_neutrals
// (index 1); write only while the core is idle.
// cmd carries transactions: operation 0 stores one Q11.20 complex entry at
// (entry_row, entry_col); operation 1 reduces the stored matrix.
// rsp returns the reduced phase block in row-major order, last_of_run on the
// final entry, or one error transaction (status 1 zero pivot, 2 bad size).
// A compute copies the stored matrix into the work memory, then eliminates
// each neutral conductor in turn, paced by the two bit-serial dividers
// and the single work memory port, then emits one entry at a time while
// rsp is ready.
// A stalled rsp holds its transaction; cmd stays low until a compute ends.
// Reset clears control state; the matrix is undefined until loaded.
// ----------------------------------------------------------------------------
module kron_matrix_reduction_core #(
	parameter int MAX_CONDUCTORS = 8,
	parameter int FRAC_BITS      = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [kmr_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [kmr_pkg::CNT_W-1:0]        cfg_data,
	kmr_cmd_if.sink                          cmd,
	kmr_rsp_if.source                        rsp
);
	localparam int CELLS = MAX_CONDUCTORS * MAX_CONDUCTORS;
	localparam int AW = $clog2(CELLS);
	localparam int IW = $clog2(MAX_CONDUCTORS);
	localparam logic [63:0] RND = 64'(1) << (FRAC_BITS - 1);

	typedef enum logic [17:0] {
		ST_IDLE = 18'h00001, ST_CPR  = 18'h00002, ST_CPW  = 18'h00004,
		ST_PRD  = 18'h00008, ST_PCHK = 18'h00010, ST_PDEN = 18'h00020,
		ST_IRD  = 18'h00040, ST_IMUL = 18'h00080, ST_INUM = 18'h00100,
		ST_IDIV = 18'h00200, ST_JRX  = 18'h00400, ST_JRW  = 18'h00800,
		ST_JMUL = 18'h01000, ST_JSUM = 18'h02000, ST_JWR  = 18'h04000,
		ST_ERD  = 18'h08000, ST_ECAP = 18'h10000, ST_ERR  = 18'h20000
	} state_t;

	state_t st_q;
	logic [kmr_pkg::CNT_W-1:0] p_q, nn_q;
	logic [AW-1:0] cp_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic [kmr_pkg::STAT_W-1:0] err_q;
	logic signed [31:0] piv_re_q, piv_im_q, fr_q, fi_q, xr_q, xi_q, wr_q, wi_q;
	logic signed [31:0] pr_q, pi_q;
	logic signed [63:0] m_q [4];
	logic [63:0] den_q;

	logic ov_q, last_q;
	logic [kmr_pkg::IDX_W-1:0] orow_q, ocol_q;
	logic signed [31:0] ore_q, oim_q;
	logic [kmr_pkg::STAT_W-1:0] ost_q;

	logic mat_we, wk_we;
	logic [AW-1:0] mat_waddr, wk_waddr, wk_raddr;
	logic [63:0] mat_rdata, wk_rdata, wk_wdata;
	logic signed [31:0] rd_re, rd_im;
	logic signed [31:0] opa [4];
	logic signed [31:0] opb [4];
	logic [4:0] n_sum;
	logic bad_size, out_free, accept, ov_set;
	logic div_start, busy_re, busy_im;
	logic signed [31:0] q_re, q_im;
	logic signed [64:0] nr, ni, sr, si;
	logic [63:0] nr_mag, ni_mag, sr_mag, si_mag;
	logic signed [32:0] dr, di;

	function automatic logic [AW-1:0] addr(logic [IW-1:0] r, logic [IW-1:0] c);
		return AW'(int'(r) * MAX_CONDUCTORS + int'(c));
	endfunction

	function automatic logic signed [31:0] sat33(logic signed [32:0] v);
		logic signed [31:0] res;
		if (v[32] != v[31])
			res = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			res = v[31:0];
		return res;
	endfunction

	assign accept   = cmd.valid && cmd.ready;
	assign cmd.ready = (st_q == ST_IDLE);
	assign out_free = !ov_q || rsp.ready;
	assign ov_set   = out_free && (st_q == ST_ECAP || st_q == ST_ERR);
	assign n_sum    = 5'(p_q) + 5'(nn_q);
	assign bad_size = (p_q == '0) || (n_sum > 5'(MAX_CONDUCTORS));
	assign rd_re    = wk_rdata[63:32];
	assign rd_im    = wk_rdata[31:0];

	assign mat_we    = accept && (cmd.operation == kmr_pkg::OP_LOAD)
		&& (int'(cmd.entry_row) < MAX_CONDUCTORS) && (int'(cmd.entry_col) < MAX_CONDUCTORS);
	assign mat_waddr = AW'(int'(cmd.entry_row) * MAX_CONDUCTORS + int'(cmd.entry_col));

	kmr_ram #(.WIDTH(64), .DEPTH(CELLS)) u_mat (
		.clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata({cmd.entry_re, cmd.entry_im}),
		.raddr(cp_q), .rdata(mat_rdata)
	);

	always_comb begin
		wk_we    = 1'b0;
		wk_waddr = addr(i_q, j_q);
		wk_wdata = {sat33(dr), sat33(di)};
		wk_raddr = addr(i_q, j_q);
		case (st_q)
			ST_CPW: begin
				wk_we    = 1'b1;
				wk_waddr = cp_q;
				wk_wdata = mat_rdata;
			end
			ST_JWR: wk_we = 1'b1;
			ST_PRD: wk_raddr = addr(k_q, k_q);
			ST_IRD: wk_raddr = addr(i_q, k_q);
			ST_JRX: wk_raddr = addr(k_q, j_q);
			default: wk_raddr = addr(i_q, j_q);
		endcase
	end

	kmr_ram #(.WIDTH(64), .DEPTH(CELLS)) u_work (
		.clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
		.raddr(wk_raddr), .rdata(wk_rdata)
	);

	// shared multiplier operands
	always_comb begin
		opa[0] = fr_q; opb[0] = xr_q;
		opa[1] = fi_q; opb[1] = xi_q;
		opa[2] = fr_q; opb[2] = xi_q;
		opa[3] = fi_q; opb[3] = xr_q;
		case (st_q)
			ST_PCHK: begin
				opa[0] = rd_re; opb[0] = rd_re;
				opa[1] = rd_im; opb[1] = rd_im;
			end
			ST_IMUL: begin
				opa[0] = rd_re; opb[0] = piv_re_q;
				opa[1] = rd_im; opb[1] = piv_im_q;
				opa[2] = rd_im; opb[2] = piv_re_q;
				opa[3] = rd_re; opb[3] = piv_im_q;
			end
			default: begin
				opa[0] = fr_q; opb[0] = xr_q;
			end
		endcase
	end

	always_comb begin
		nr = {m_q[0][63], m_q[0]} + {m_q[1][63], m_q[1]};
		ni = {m_q[2][63], m_q[2]} - {m_q[3][63], m_q[3]};
		sr = {m_q[0][63], m_q[0]} - {m_q[1][63], m_q[1]};
		si = {m_q[2][63], m_q[2]} + {m_q[3][63], m_q[3]};
		nr_mag = nr[64] ? 64'(-nr) : nr[63:0];
		ni_mag = ni[64] ? 64'(-ni) : ni[63:0];
		sr_mag = sr[64] ? 64'(-sr) : sr[63:0];
		si_mag = si[64] ? 64'(-si) : si[63:0];
		dr = {wr_q[31], wr_q} - {pr_q[31], pr_q};
		di = {wi_q[31], wi_q} - {pi_q[31], pi_q};
	end

	assign div_start = (st_q == ST_INUM);

	kmr_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
		.clk(clk), .arst_n(arst_n), .start(div_start), .neg(nr[64]), .num(nr_mag),
		.den(den_q), .busy(busy_re), .quo(q_re)
	);

	kmr_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
		.clk(clk), .arst_n(arst_n), .start(div_start), .neg(ni[64]), .num(ni_mag),
		.den(den_q), .busy(busy_im), .quo(q_im)
	);

	always_ff @(posedge clk) begin
		for (int n = 0; n < 4; n++)
			m_q[n] <= opa[n] * opb[n];
		case (st_q)
			ST_PCHK: begin
				piv_re_q <= rd_re;
				piv_im_q <= rd_im;
			end
			ST_PDEN: den_q <= 64'(m_q[0]) + 64'(m_q[1]);
			ST_IDIV: begin
				fr_q <= q_re;
				fi_q <= q_im;
			end
			ST_JRW: begin
				xr_q <= rd_re;
				xi_q <= rd_im;
			end
			ST_JMUL: begin
				wr_q <= rd_re;
				wi_q <= rd_im;
			end
			ST_JSUM: begin
				pr_q <= kmr_pkg::sat_mag(65'((sr_mag + RND) >> FRAC_BITS), sr[64]);
				pi_q <= kmr_pkg::sat_mag(65'((si_mag + RND) >> FRAC_BITS), si[64]);
			end
			default: begin
				den_q <= den_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			p_q   <= 3'd3;
			nn_q  <= 3'd1;
			cp_q  <= '0;
			i_q   <= '0;
			j_q   <= '0;
			k_q   <= '0;
			err_q <= kmr_pkg::STATUS_OK;
			ov_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					kmr_pkg::CFG_NUM_PHASES:   p_q  <= cfg_data;
					kmr_pkg::CFG_NUM_NEUTRALS: nn_q <= cfg_data;
					default: p_q <= p_q;
				endcase
			end
			if (ov_set)
				ov_q <= 1'b1;
			else if (rsp.valid && rsp.ready)
				ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept && cmd.operation == kmr_pkg::OP_COMPUTE) begin
						cp_q <= '0;
						if (bad_size) begin
							err_q <= kmr_pkg::STATUS_BAD_SIZE;
							st_q  <= ST_ERR;
						end else
							st_q <= ST_CPR;
					end
				end
				ST_CPR: st_q <= ST_CPW;
				ST_CPW: begin
					cp_q <= cp_q + AW'(1);
					i_q  <= '0;
					j_q  <= '0;
					k_q  <= IW'(n_sum - 5'd1);
					if (cp_q != AW'(CELLS - 1))
						st_q <= ST_CPR;
					else if (nn_q == '0)
						st_q <= ST_ERD;
					else
						st_q <= ST_PRD;
				end
				ST_PRD: st_q <= ST_PCHK;
				ST_PCHK: begin
					if (rd_re == '0 && rd_im == '0) begin
						err_q <= kmr_pkg::STATUS_SINGULAR;
						st_q  <= ST_ERR;
					end else
						st_q <= ST_PDEN;
				end
				ST_PDEN: begin
					i_q  <= '0;
					st_q <= ST_IRD;
				end
				ST_IRD:  st_q <= ST_IMUL;
				ST_IMUL: st_q <= ST_INUM;
				ST_INUM: st_q <= ST_IDIV;
				ST_IDIV: begin
					if (!busy_re && !busy_im) begin
						j_q  <= '0;
						st_q <= ST_JRX;
					end
				end
				ST_JRX:  st_q <= ST_JRW;
				ST_JRW:  st_q <= ST_JMUL;
				ST_JMUL: st_q <= ST_JSUM;
				ST_JSUM: st_q <= ST_JWR;
				ST_JWR: begin
					if (j_q != k_q - IW'(1)) begin
						j_q  <= j_q + IW'(1);
						st_q <= ST_JRX;
					end else if (i_q != k_q - IW'(1)) begin
						i_q  <= i_q + IW'(1);
						st_q <= ST_IRD;
					end else if (5'(k_q) != 5'(p_q)) begin
						k_q  <= k_q - IW'(1);
						st_q <= ST_PRD;
					end else begin
						i_q  <= '0;
						j_q  <= '0;
						st_q <= ST_ERD;
					end
				end
				ST_ERD: st_q <= ST_ECAP;
				ST_ECAP: begin
					if (out_free) begin
						if (5'(j_q) != 5'(p_q) - 5'd1) begin
							j_q  <= j_q + IW'(1);
							st_q <= ST_ERD;
						end else if (5'(i_q) != 5'(p_q) - 5'd1) begin
							j_q  <= '0;
							i_q  <= i_q + IW'(1);
							st_q <= ST_ERD;
						end else
							st_q <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (out_free)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_ECAP && out_free) begin
			orow_q <= kmr_pkg::IDX_W'(i_q);
			ocol_q <= kmr_pkg::IDX_W'(j_q);
			ore_q  <= rd_re;
			oim_q  <= rd_im;
			ost_q  <= kmr_pkg::STATUS_OK;
			last_q <= (5'(i_q) == 5'(p_q) - 5'd1) && (5'(j_q) == 5'(p_q) - 5'd1);
		end else if (st_q == ST_ERR && out_free) begin
			orow_q <= '0;
			ocol_q <= '0;
			ore_q  <= '0;
			oim_q  <= '0;
			ost_q  <= err_q;
			last_q <= 1'b1;
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.result_row  = orow_q;
	assign rsp.result_col  = ocol_q;
	assign rsp.result_re   = ore_q;
	assign rsp.result_im   = oim_q;
	assign rsp.last_of_run = last_q;
	assign rsp.status      = ost_q;

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != kmr_pkg::STATUS_OK |-> rsp.last_of_run)
		else $error("error transaction without last_of_run");

	a_div_idle_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_JRX |-> !busy_re && !busy_im)
		else $error("update started while divider busy");

	a_update_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_JWR |-> i_q < k_q && j_q < k_q)
		else $error("update outside remaining block");

	a_load_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.operation == kmr_pkg::OP_LOAD |=> st_q == ST_IDLE)
		else $error("load left idle state");
endmodule
